[hdl/ipfp_pkg.sv]
// ----------------------------------------------------------------------------
// ipfp_pkg: shared types and constants of the position frame parser
// Header bytes, frame positions and the position fix record that travels
// from the frame tracker to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package ipfp_pkg;

   localparam logic [7:0] HDR_SYNC  = 8'hFA;
   localparam logic [7:0] HDR_ID    = 8'hFF;
   localparam logic [7:0] HDR_MID   = 8'h32;
   localparam logic [7:0] HDR_LEN   = 8'h0E;

   localparam int unsigned POS_WIDTH = 5;

   // Frame positions: 0 hunts for the sync byte, 1..3 expect header bytes,
   // 4..17 take payload bytes, 18 takes the checksum.
   localparam logic [POS_WIDTH-1:0] POS_HUNT     = 5'd0;
   localparam logic [POS_WIDTH-1:0] POS_FIRST    = 5'd1;
   localparam logic [POS_WIDTH-1:0] POS_PAYLOAD  = 5'd4;
   localparam logic [POS_WIDTH-1:0] POS_WORD_END = 5'd16;
   localparam logic [POS_WIDTH-1:0] POS_CHECK    = 5'd18;

   typedef struct packed {
      logic [31:0] latitude_bits;
      logic [31:0] longitude_bits;
      logic [31:0] altitude_bits;
   } fix_type;

   // Header byte expected at frame positions 1 to 3.
   function automatic logic [7:0] header_byte(input logic [1:0] pos);
      logic [7:0] want;
      case (pos)
         2'd1:    want = HDR_ID;
         2'd2:    want = HDR_MID;
         2'd3:    want = HDR_LEN;
         default: want = HDR_SYNC;
      endcase
      return want;
   endfunction

endpackage

`default_nettype wire

[hdl/ipfp_tracker.sv]
// ----------------------------------------------------------------------------
// ipfp_tracker: frame position, running checksum and word assembly
// Advances by one byte on each step and flags a byte that would close a
// frame with a good checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfp_tracker
   import ipfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output logic            check_pass,
   output fix_type         fix
);

   logic [POS_WIDTH-1:0] pos_ff;
   logic [POS_WIDTH-1:0] pos_in;
   logic [7:0]           sum_ff;
   logic [7:0]           sum_in;
   logic [7:0]           sum_add;
   logic [31:0]          word_ff [3];
   logic [2:0]           word_we;
   logic [POS_WIDTH-1:0] idx;
   logic                 is_sync;

   assign sum_add    = sum_ff + rx_byte;
   assign is_sync    = (rx_byte == HDR_SYNC);
   assign idx        = pos_ff - POS_PAYLOAD;
   assign check_pass = (pos_ff == POS_CHECK) && (sum_add == 8'd0);

   assign fix.latitude_bits  = word_ff[0];
   assign fix.longitude_bits = word_ff[1];
   assign fix.altitude_bits  = word_ff[2];

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      word_we = 3'b000;
      if (pos_ff == POS_HUNT || pos_ff > POS_CHECK) begin
         sum_in = 8'd0;
         pos_in = is_sync ? POS_FIRST : POS_HUNT;
      end else if (pos_ff < POS_PAYLOAD) begin
         if (rx_byte == header_byte(pos_ff[1:0])) begin
            sum_in = sum_add;
            pos_in = pos_ff + 1'b1;
         end else begin
            // A mismatching sync byte opens a new frame at once.
            sum_in = 8'd0;
            pos_in = is_sync ? POS_FIRST : POS_HUNT;
         end
      end else if (pos_ff < POS_CHECK) begin
         sum_in = sum_add;
         pos_in = pos_ff + 1'b1;
         if (pos_ff < POS_WORD_END) begin
            case (idx[3:2])
               2'd0:    word_we = 3'b001;
               2'd1:    word_we = 3'b010;
               2'd2:    word_we = 3'b100;
               default: word_we = 3'b000;
            endcase
         end
      end else begin
         sum_in = 8'd0;
         pos_in = POS_HUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= 8'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (step && word_we[i]) begin
            word_ff[i] <= {word_ff[i][23:0], rx_byte};
         end
      end
   end

endmodule

`default_nettype wire

[hdl/imu_position_frame_parser.sv]
// ----------------------------------------------------------------------------
// imu_position_frame_parser: position frame parser for a serial sensor link
// Finds FA FF 32 0E frames in a byte stream, checks the additive checksum
// and reports latitude, longitude and altitude words.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one received byte per transfer. The rsp_ channel
// carries one position fix per frame whose 8-bit sum of all bytes after the
// sync byte, checksum included, is zero; frames with a bad sum are dropped.
// A byte is taken into an input register and processed from there; a good
// checksum byte loads its fix into the output register that drives rsp_valid.
// One byte is accepted every cycle while req_stall is low; the rate is set
// by the position and checksum update in the tracker.
// When rsp_stall holds a fix in the output register, bytes keep flowing
// until another good checksum byte reaches the tracker; that byte waits
// in the input register and req_stall rises until the fix is taken.
// Synchronous reset returns the parser to hunting for the sync byte and
// empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_position_frame_parser
   import ipfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_latitude_bits,
   output logic [31:0]      rsp_longitude_bits,
   output logic [31:0]      rsp_altitude_bits
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   fix_type    fix_ff;
   fix_type    fix;
   logic       check_pass;
   logic       out_free;
   logic       consume;
   logic       load;
   logic       req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && (!check_pass || out_free);
   assign load      = consume && check_pass;
   assign req_stall = in_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   ipfp_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (consume),
      .rx_byte    (in_byte_ff),
      .check_pass (check_pass),
      .fix        (fix)
   );

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (load) begin
         fix_ff <= fix;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_latitude_bits  = fix_ff.latitude_bits;
   assign rsp_longitude_bits = fix_ff.longitude_bits;
   assign rsp_altitude_bits  = fix_ff.altitude_bits;

endmodule

`default_nettype wire

[dv/imu_position_frame_parser_tb.sv]
// ----------------------------------------------------------------------------
// imu_position_frame_parser_tb: self-checking bench for the position parser
// Streams header, payload and checksum bytes into the parser, predicts each
// position fix in the bench and compares every fix field by field. Both
// channels idle at random, and the output is held off long enough to stall
// the input.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_position_frame_parser_tb;
   import ipfp_pkg::*;

   localparam int PAYLOAD_BYTES = 14;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_latitude_bits;
   logic [31:0] rsp_longitude_bits;
   logic [31:0] rsp_altitude_bits;

   // Parser state as the bench predicts it.
   logic [POS_WIDTH-1:0] parse_pos = POS_HUNT;
   logic [7:0]           frame_sum = 8'h00;
   logic [31:0]          word_acc [3];
   fix_type              fix_queue [$];

   logic [7:0] frame_payload [PAYLOAD_BYTES];
   int         errors = 0;
   int         bytes_sent = 0;
   bit         req_idle_on = 1'b1;
   bit         rsp_idle_on = 1'b1;
   int         hold_request = 0;
   int         hold_left = 0;
   int         burst_left = 0;

   imu_position_frame_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_latitude_bits  (rsp_latitude_bits),
      .rsp_longitude_bits (rsp_longitude_bits),
      .rsp_altitude_bits  (rsp_altitude_bits)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("imu_position_frame_parser_tb failed");
      $finish;
   end

   function automatic logic [7:0] header_at(input logic [POS_WIDTH-1:0] pos);
      logic [7:0] want;
      case (pos)
         POS_FIRST:      want = HDR_ID;
         POS_FIRST + 1:  want = HDR_MID;
         POS_FIRST + 2:  want = HDR_LEN;
         default:        want = HDR_SYNC;
      endcase
      return want;
   endfunction

   // A sync byte that breaks the header starts a new frame at once.
   function automatic void restart_hunt(input logic [7:0] b);
      frame_sum = 8'h00;
      parse_pos = (b == HDR_SYNC) ? POS_FIRST : POS_HUNT;
   endfunction

   function automatic void track_byte(input logic [7:0] b);
      fix_type fix;
      int unsigned widx;
      if (parse_pos == POS_HUNT || parse_pos > POS_CHECK) begin
         restart_hunt(b);
      end else if (parse_pos < POS_PAYLOAD) begin
         if (b == header_at(parse_pos)) begin
            frame_sum = frame_sum + b;
            parse_pos = parse_pos + 1'b1;
         end else begin
            restart_hunt(b);
         end
      end else begin
         frame_sum = frame_sum + b;
         if (parse_pos < POS_CHECK) begin
            if (parse_pos < POS_WORD_END) begin
               widx = (parse_pos - POS_PAYLOAD) >> 2;
               word_acc[widx] = {word_acc[widx][23:0], b};
            end
            parse_pos = parse_pos + 1'b1;
         end else begin
            parse_pos = POS_HUNT;
            if (frame_sum == 8'h00) begin
               fix.latitude_bits  = word_acc[0];
               fix.longitude_bits = word_acc[1];
               fix.altitude_bits  = word_acc[2];
               fix_queue.push_back(fix);
            end
            frame_sum = 8'h00;
         end
      end
   endfunction

   // Receiver side: random stall bursts, or one long hold when requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (burst_left != 0) begin
         burst_left = burst_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      fix_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fix_queue.size() == 0) begin
            $error("position fix with none expected: %h %h %h",
                   rsp_latitude_bits, rsp_longitude_bits, rsp_altitude_bits);
            errors++;
         end else begin
            want = fix_queue.pop_front();
            if (rsp_latitude_bits !== want.latitude_bits) begin
               $error("latitude_bits: expected %h, actual %h",
                      want.latitude_bits, rsp_latitude_bits);
               errors++;
            end
            if (rsp_longitude_bits !== want.longitude_bits) begin
               $error("longitude_bits: expected %h, actual %h",
                      want.longitude_bits, rsp_longitude_bits);
               errors++;
            end
            if (rsp_altitude_bits !== want.altitude_bits) begin
               $error("altitude_bits: expected %h, actual %h",
                      want.altitude_bits, rsp_altitude_bits);
               errors++;
            end
         end
      end
   end

   // Called right after a rising edge; returns right after the edge at which
   // the byte transfer took place.
   task automatic send_byte(input logic [7:0] b);
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      track_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input bit good);
      logic [7:0] total;
      total = HDR_ID + HDR_MID + HDR_LEN;
      foreach (frame_payload[i]) total = total + frame_payload[i];
      send_byte(HDR_SYNC);
      send_byte(HDR_ID);
      send_byte(HDR_MID);
      send_byte(HDR_LEN);
      foreach (frame_payload[i]) send_byte(frame_payload[i]);
      if (good)
         send_byte(8'(~total + 8'd1));
      else
         send_byte(8'(~total + 8'd1 + 8'($urandom_range(1, 255))));
   endtask

   task automatic fill_random_payload();
      foreach (frame_payload[i]) frame_payload[i] = 8'($urandom);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (fix_queue.size() != 0) @(posedge clock);
   endtask

   // Broken headers, sync bytes inside the header, then a good frame.
   task automatic test_header_resync();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_SYNC);
      send_byte(HDR_ID);
      send_byte(8'h33);
      send_byte(HDR_SYNC);
      send_byte(HDR_SYNC);
      send_byte(HDR_ID);
      send_byte(HDR_MID);
      foreach (frame_payload[i]) frame_payload[i] = i[0] ? 8'hFF : 8'h00;
      send_frame(1'b1);
   endtask

   task automatic test_checksum_cases();
      logic [7:0] partial;
      foreach (frame_payload[i]) frame_payload[i] = 8'hFF;
      send_frame(1'b0);
      foreach (frame_payload[i]) frame_payload[i] = 8'h00;
      send_frame(1'b1);
      // Sync bytes as payload, and the last payload byte chosen so that the
      // checksum itself is a sync byte.
      partial = HDR_ID + HDR_MID + HDR_LEN + HDR_SYNC;
      for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
         frame_payload[i] = HDR_SYNC;
         partial = partial + HDR_SYNC;
      end
      frame_payload[PAYLOAD_BYTES-1] = 8'(~partial + 8'd1);
      send_frame(1'b1);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int stop_at;
      int depth;
      logic [7:0] b;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(0, 9))
            6: begin
               fill_random_payload();
               send_frame(1'b0);
            end
            7: begin
               // Header broken after a random number of good bytes.
               depth = $urandom_range(1, 3);
               send_byte(HDR_SYNC);
               for (int k = 1; k < depth; k++) send_byte(header_at(k));
               b = 8'($urandom);
               if ($urandom_range(0, 2) == 0) b = HDR_SYNC;
               if (b == header_at(depth)) b = b ^ 8'h01;
               send_byte(b);
            end
            8: begin
               repeat ($urandom_range(1, 5))
                  send_byte(($urandom_range(0, 3) == 0) ? HDR_SYNC : 8'($urandom));
            end
            9: begin
               send_byte(HDR_SYNC);
               fill_random_payload();
               send_frame(1'b1);
            end
            default: begin
               fill_random_payload();
               send_frame(1'b1);
            end
         endcase
      end
   endtask

   // The output is held while good frames keep coming, so the input stalls.
   task automatic test_output_hold();
      hold_request = 250;
      repeat (6) begin
         fill_random_payload();
         send_frame(1'b1);
      end
      wait_drained();
   endtask

   task automatic test_quiet_tail();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(120);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_resync();
      test_checksum_cases();
      test_random_traffic(150);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(80);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_random_traffic(150);
      test_output_hold();
      test_quiet_tail();
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0 && fix_queue.size() == 0) begin
         $display("imu_position_frame_parser_tb passed");
      end else begin
         $display("imu_position_frame_parser_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/ipfp_pkg.sv
hdl/ipfp_tracker.sv
hdl/imu_position_frame_parser.sv
dv/imu_position_frame_parser_tb.sv
